### hdl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types, character codes and result helpers shared by the string escape
// decoder and its decode stage.
// ----------------------------------------------------------------------------
package sed_pkg;

	// width of a character code on the ports
	localparam int CODE_W    = 21;
	// width of the digit-run accumulator; digits wrap at this width
	localparam int CHAR_BITS = 21;

	localparam logic [CODE_W-1:0] CH_BSLASH = CODE_W'('h5C);
	localparam logic [CODE_W-1:0] CH_X      = CODE_W'('h78);
	localparam logic [CODE_W-1:0] CH_ZERO   = CODE_W'('h30);
	localparam logic [CODE_W-1:0] CH_ONE    = CODE_W'('h31);
	localparam logic [CODE_W-1:0] CH_SEVEN  = CODE_W'('h37);
	localparam logic [CODE_W-1:0] CH_NINE   = CODE_W'('h39);
	localparam logic [CODE_W-1:0] CH_LO_A   = CODE_W'('h61);
	localparam logic [CODE_W-1:0] CH_LO_F   = CODE_W'('h66);
	localparam logic [CODE_W-1:0] CH_UP_A   = CODE_W'('h41);
	localparam logic [CODE_W-1:0] CH_UP_F   = CODE_W'('h46);
	localparam logic [CODE_W-1:0] CH_LO_N   = CODE_W'('h6E);
	localparam logic [CODE_W-1:0] CH_LO_T   = CODE_W'('h74);
	localparam logic [CODE_W-1:0] CH_LO_R   = CODE_W'('h72);
	localparam logic [CODE_W-1:0] CH_LO_V   = CODE_W'('h76);
	localparam logic [CODE_W-1:0] CH_LO_AL  = CODE_W'('h61);
	localparam logic [CODE_W-1:0] CH_LO_B   = CODE_W'('h62);
	localparam logic [CODE_W-1:0] CH_LO_FF  = CODE_W'('h66);
	localparam logic [CODE_W-1:0] CH_QUOTE  = CODE_W'('h27);
	localparam logic [CODE_W-1:0] CH_DQUOTE = CODE_W'('h22);

	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_ESC    = 5'b00010,
		MODE_OCT    = 5'b00100,
		MODE_HEX    = 5'b01000,
		MODE_DROP   = 5'b10000
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_UNTERMINATED = 2'd1,
		ERR_UNKNOWN      = 2'd2,
		ERR_EMPTY_HEX    = 2'd3
	} err_t;

	typedef struct packed {
		logic [CODE_W-1:0] char_value;
		kind_t             kind;
		err_t              error_code;
		logic              last_in_item;
	} res_t;

	typedef struct packed {
		mode_t                mode;
		logic [CHAR_BITS-1:0] acc;
		logic                 digit_seen;
	} state_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} step_t;

	function automatic res_t res_char(input logic [CODE_W-1:0] v);
		res_t r;
		r.char_value   = v;
		r.kind         = KIND_CHAR;
		r.error_code   = ERR_NONE;
		r.last_in_item = 1'b0;
		return r;
	endfunction

	function automatic res_t res_end();
		res_t r;
		r.char_value   = '0;
		r.kind         = KIND_END;
		r.error_code   = ERR_NONE;
		r.last_in_item = 1'b0;
		return r;
	endfunction

	function automatic res_t res_err(input err_t e);
		res_t r;
		r.char_value   = '0;
		r.kind         = KIND_ERR;
		r.error_code   = e;
		r.last_in_item = 1'b0;
		return r;
	endfunction

endpackage

### hdl/sed_in_if.sv
// ----------------------------------------------------------------------------
// sed_in_if
// Character channel into the decoder: one source character or end marker
// per word.
// ----------------------------------------------------------------------------
interface sed_in_if;
	logic                       valid;
	logic                       ready;
	logic [sed_pkg::CODE_W-1:0] char_code;
	logic                       end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

### hdl/sed_out_if.sv
// ----------------------------------------------------------------------------
// sed_out_if
// Result channel out of the decoder: one character, end marker or error
// per word.
// ----------------------------------------------------------------------------
interface sed_out_if;
	logic                       valid;
	logic                       ready;
	logic [sed_pkg::CODE_W-1:0] char_value;
	logic [1:0]                 kind;
	logic [1:0]                 error_code;
	logic                       last_in_item;

	modport source (output valid, output char_value, output kind, output error_code,
		output last_in_item, input ready);
	modport sink   (input valid, input char_value, input kind, input error_code,
		input last_in_item, output ready);
endinterface

### hdl/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// Escape decode for one character: next decoder state and up to two
// results from the current state and the registered character.
// ----------------------------------------------------------------------------
module sed_decode (
	input  sed_pkg::state_t             st,
	input  logic [sed_pkg::CODE_W-1:0]  char_code,
	input  logic                        end_of_string,
	output sed_pkg::state_t             nxt,
	output sed_pkg::step_t              step
);

	logic                          is_bslash;
	logic                          is_oct;
	logic                          is_oct_start;
	logic                          is_dec;
	logic                          is_hex_alpha;
	logic                          is_hex;
	logic [3:0]                    hex_val;
	logic                          single_hit;
	logic [sed_pkg::CODE_W-1:0]    single_val;
	logic                          plain_has;
	sed_pkg::res_t                 plain_res;
	sed_pkg::mode_t                plain_mode;
	logic [1:0]                    cnt;
	sed_pkg::res_t                 r0;
	sed_pkg::res_t                 r1;
	logic [sed_pkg::CODE_W-1:0]    acc_out;

	assign is_bslash    = (char_code == sed_pkg::CH_BSLASH);
	assign is_oct       = (char_code >= sed_pkg::CH_ZERO) && (char_code <= sed_pkg::CH_SEVEN);
	assign is_oct_start = (char_code >= sed_pkg::CH_ONE) && (char_code <= sed_pkg::CH_SEVEN);
	assign is_dec       = (char_code >= sed_pkg::CH_ZERO) && (char_code <= sed_pkg::CH_NINE);
	assign is_hex_alpha = ((char_code >= sed_pkg::CH_LO_A) && (char_code <= sed_pkg::CH_LO_F))
		|| ((char_code >= sed_pkg::CH_UP_A) && (char_code <= sed_pkg::CH_UP_F));
	assign is_hex       = is_dec || is_hex_alpha;
	// letters sit at 1..6 in their low nibble
	assign hex_val      = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
	assign acc_out      = sed_pkg::CODE_W'(st.acc);

	always_comb begin
		single_hit = 1'b1;
		single_val = '0;
		case (char_code)
			sed_pkg::CH_LO_N:   single_val = sed_pkg::CODE_W'(10);
			sed_pkg::CH_LO_T:   single_val = sed_pkg::CODE_W'(9);
			sed_pkg::CH_LO_R:   single_val = sed_pkg::CODE_W'(13);
			sed_pkg::CH_ZERO:   single_val = sed_pkg::CODE_W'(0);
			sed_pkg::CH_LO_V:   single_val = sed_pkg::CODE_W'(11);
			sed_pkg::CH_LO_AL:  single_val = sed_pkg::CODE_W'(7);
			sed_pkg::CH_LO_B:   single_val = sed_pkg::CODE_W'(8);
			sed_pkg::CH_LO_FF:  single_val = sed_pkg::CODE_W'(12);
			sed_pkg::CH_QUOTE:  single_val = sed_pkg::CODE_W'(39);
			sed_pkg::CH_DQUOTE: single_val = sed_pkg::CODE_W'(34);
			sed_pkg::CH_BSLASH: single_val = sed_pkg::CODE_W'(92);
			default:            single_hit = 1'b0;
		endcase
	end

	// handling of a character as in normal mode
	always_comb begin
		plain_has  = end_of_string || !is_bslash;
		plain_res  = end_of_string ? sed_pkg::res_end() : sed_pkg::res_char(char_code);
		plain_mode = (!end_of_string && is_bslash) ? sed_pkg::MODE_ESC : sed_pkg::MODE_NORMAL;
	end

	always_comb begin
		nxt = st;
		cnt = 2'd0;
		r0  = sed_pkg::res_end();
		r1  = sed_pkg::res_end();
		unique case (st.mode)
			sed_pkg::MODE_ESC: begin
				if (end_of_string) begin
					r0       = sed_pkg::res_err(sed_pkg::ERR_UNTERMINATED);
					r1       = sed_pkg::res_end();
					cnt      = 2'd2;
					nxt.mode = sed_pkg::MODE_NORMAL;
				end else if (single_hit) begin
					r0       = sed_pkg::res_char(single_val);
					cnt      = 2'd1;
					nxt.mode = sed_pkg::MODE_NORMAL;
				end else if (char_code == sed_pkg::CH_X) begin
					nxt.acc        = '0;
					nxt.digit_seen = 1'b0;
					nxt.mode       = sed_pkg::MODE_HEX;
				end else if (is_oct_start) begin
					nxt.acc        = sed_pkg::CHAR_BITS'(char_code[2:0]);
					nxt.digit_seen = 1'b1;
					nxt.mode       = sed_pkg::MODE_OCT;
				end else begin
					r0       = sed_pkg::res_err(sed_pkg::ERR_UNKNOWN);
					cnt      = 2'd1;
					nxt.mode = sed_pkg::MODE_DROP;
				end
			end
			sed_pkg::MODE_OCT: begin
				if (!end_of_string && is_oct) begin
					nxt.acc = {st.acc[sed_pkg::CHAR_BITS-4:0], char_code[2:0]};
				end else begin
					r0             = sed_pkg::res_char(acc_out);
					r1             = plain_res;
					cnt            = plain_has ? 2'd2 : 2'd1;
					nxt.acc        = '0;
					nxt.digit_seen = 1'b0;
					nxt.mode       = plain_mode;
				end
			end
			sed_pkg::MODE_HEX: begin
				if (!end_of_string && is_hex) begin
					nxt.acc        = {st.acc[sed_pkg::CHAR_BITS-5:0], hex_val};
					nxt.digit_seen = 1'b1;
				end else if (st.digit_seen) begin
					r0             = sed_pkg::res_char(acc_out);
					r1             = plain_res;
					cnt            = plain_has ? 2'd2 : 2'd1;
					nxt.acc        = '0;
					nxt.digit_seen = 1'b0;
					nxt.mode       = plain_mode;
				end else begin
					r0             = sed_pkg::res_err(sed_pkg::ERR_EMPTY_HEX);
					r1             = sed_pkg::res_end();
					cnt            = end_of_string ? 2'd2 : 2'd1;
					nxt.acc        = '0;
					nxt.digit_seen = 1'b0;
					nxt.mode       = end_of_string ? sed_pkg::MODE_NORMAL : sed_pkg::MODE_DROP;
				end
			end
			sed_pkg::MODE_DROP: begin
				if (end_of_string) begin
					r0       = sed_pkg::res_end();
					cnt      = 2'd1;
					nxt.mode = sed_pkg::MODE_NORMAL;
				end
			end
			default: begin
				nxt.acc        = '0;
				nxt.digit_seen = 1'b0;
				r0             = plain_res;
				cnt            = plain_has ? 2'd1 : 2'd0;
				nxt.mode       = plain_mode;
			end
		endcase
		// mark the final result of this character
		r0.last_in_item = (cnt == 2'd1);
		r1.last_in_item = 1'b1;
	end

	assign step.count = cnt;
	assign step.r0    = r0;
	assign step.r1    = r1;

endmodule

### hdl/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes C string escapes one character per word and emits the unescaped
// characters, an end marker per string and error words.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                        Words
//  in_ch     in   char_code[20:0], end_of_string                 one per char
//  out_ch    out  char_value[20:0], kind, error_code, last_in_item  0..2 per in
//
// One character is taken per cycle while the input register is empty or its
// character is consumed. It is held in an input register, decoded and its
// results are written to a two-word result queue; with the queue empty, its
// first word is on out_ch once it has passed the input register and the
// result queue. A character waits in the input register while the queue
// cannot take all of its words. A stalled output holds the queue, then the input register.
// Reset clears the decoder to normal mode and empties both registers.
//
module string_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	sed_in_if.sink      in_ch,
	sed_out_if.source   out_ch
);

	logic                       valid_s1;
	logic [sed_pkg::CODE_W-1:0] char_s1;
	logic                       eos_s1;

	sed_pkg::state_t            state_q;
	sed_pkg::state_t            state_nxt;
	sed_pkg::step_t             step;

	sed_pkg::res_t              res_q [2];
	sed_pkg::res_t              res_d [2];
	logic [1:0]                 cnt_q;
	logic [1:0]                 cnt_d;
	logic [1:0]                 base;
	logic                       pop;
	logic                       consume;
	logic                       accept;

	sed_decode u_decode (
		.st            (state_q),
		.char_code     (char_s1),
		.end_of_string (eos_s1),
		.nxt           (state_nxt),
		.step          (step)
	);

	assign pop     = (cnt_q != 2'd0) && out_ch.ready;
	assign base    = cnt_q - {1'b0, pop};
	// take the held character only when its words fit the queue
	assign consume = valid_s1 && (({1'b0, base} + {1'b0, step.count}) <= 3'd2);
	assign in_ch.ready = !valid_s1 || consume;
	assign accept  = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_ch.char_code;
			eos_s1  <= in_ch.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= sed_pkg::MODE_NORMAL;
			state_q.acc        <= '0;
			state_q.digit_seen <= 1'b0;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		res_d[0] = res_q[0];
		res_d[1] = res_q[1];
		if (pop) begin
			res_d[0] = res_q[1];
		end
		if (consume && (step.count != 2'd0)) begin
			res_d[base[0]] = step.r0;
		end
		if (consume && (step.count == 2'd2)) begin
			res_d[1] = step.r1;
		end
		cnt_d = consume ? (base + step.count) : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q[0] <= res_d[0];
		res_q[1] <= res_d[1];
	end

	assign out_ch.valid        = (cnt_q != 2'd0);
	assign out_ch.char_value   = res_q[0].char_value;
	assign out_ch.kind         = res_q[0].kind;
	assign out_ch.error_code   = res_q[0].error_code;
	assign out_ch.last_in_item = res_q[0].last_in_item;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for string_escape_decoder. A driver pushes characters
// and end markers from a queue, a behavioural decoder works out the result
// words each accepted character should give, and a monitor compares every
// result word field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sed_pkg::*;

	// no random stalls while the last few words go through
	localparam int TAIL_WORDS = 60;
	localparam int RANDOM_WORDS = 650;

	localparam logic [CODE_W-1:0] ESC_CHARS [11] = '{CH_LO_N, CH_LO_T, CH_LO_R, CH_ZERO,
		CH_LO_V, CH_LO_AL, CH_LO_B, CH_LO_FF, CH_QUOTE, CH_DQUOTE, CH_BSLASH};

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              eos;
		logic              hold;
	} src_word_t;

	logic clk = 1'b0;
	logic arst_n;

	sed_in_if  in_ch();
	sed_out_if out_ch();

	string_escape_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	src_word_t word_q[$];
	res_t      want_q[$];
	res_t      step_out[$];

	mode_t                dec_mode;
	logic [CHAR_BITS-1:0] dec_acc;
	logic                 dec_digit;

	bit hold_next;
	int err_cnt, words_sent, strings_sent, results_seen, chars_seen, ends_seen, errs_seen;
	int src_gap, src_run, sink_gap, sink_run;

	// ---------------------------------------------------------------- decoder

	function automatic void emit(input logic [CODE_W-1:0] v, input kind_t k, input err_t e);
		res_t r;
		r.char_value   = v;
		r.kind         = k;
		r.error_code   = e;
		r.last_in_item = 1'b0;
		step_out.insert(step_out.size(), r);
	endfunction

	function automatic void clear_run();
		dec_acc   = '0;
		dec_digit = 1'b0;
	endfunction

	function automatic void plain_step(input logic [CODE_W-1:0] c, input logic eos);
		if (eos) begin
			emit('0, KIND_END, ERR_NONE);
			dec_mode = MODE_NORMAL;
		end else if (c == CH_BSLASH) begin
			dec_mode = MODE_ESC;
		end else begin
			emit(c, KIND_CHAR, ERR_NONE);
			dec_mode = MODE_NORMAL;
		end
	endfunction

	function automatic int hex_value(input logic [CODE_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F)
			return int'(c - CH_LO_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F)
			return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic bit simple_escape(input logic [CODE_W-1:0] c, output logic [CODE_W-1:0] v);
		v = '0;
		case (c)
			CH_LO_N:   v = CODE_W'(10);
			CH_LO_T:   v = CODE_W'(9);
			CH_LO_R:   v = CODE_W'(13);
			CH_ZERO:   v = CODE_W'(0);
			CH_LO_V:   v = CODE_W'(11);
			CH_LO_AL:  v = CODE_W'(7);
			CH_LO_B:   v = CODE_W'(8);
			CH_LO_FF:  v = CODE_W'(12);
			CH_QUOTE:  v = CODE_W'(39);
			CH_DQUOTE: v = CODE_W'(34);
			CH_BSLASH: v = CODE_W'(92);
			default:   return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// work out the result words of one accepted word and queue them
	function automatic void decode_word(input logic [CODE_W-1:0] c, input logic eos);
		logic [CODE_W-1:0] v;
		int d;
		step_out.delete();
		case (dec_mode)
			MODE_ESC: begin
				if (eos) begin
					emit('0, KIND_ERR, ERR_UNTERMINATED);
					emit('0, KIND_END, ERR_NONE);
					dec_mode = MODE_NORMAL;
				end else if (simple_escape(c, v)) begin
					emit(v, KIND_CHAR, ERR_NONE);
					dec_mode = MODE_NORMAL;
				end else if (c == CH_X) begin
					clear_run();
					dec_mode = MODE_HEX;
				end else if (c >= CH_ONE && c <= CH_SEVEN) begin
					dec_acc   = CHAR_BITS'(c - CH_ZERO);
					dec_digit = 1'b1;
					dec_mode  = MODE_OCT;
				end else begin
					emit('0, KIND_ERR, ERR_UNKNOWN);
					dec_mode = MODE_DROP;
				end
			end
			MODE_OCT: begin
				if (!eos && c >= CH_ZERO && c <= CH_SEVEN) begin
					dec_acc = (dec_acc << 3) | CHAR_BITS'(c - CH_ZERO);
				end else begin
					emit(CODE_W'(dec_acc), KIND_CHAR, ERR_NONE);
					clear_run();
					plain_step(c, eos);
				end
			end
			MODE_HEX: begin
				d = eos ? -1 : hex_value(c);
				if (d >= 0) begin
					dec_acc   = (dec_acc << 4) | CHAR_BITS'(d);
					dec_digit = 1'b1;
				end else if (dec_digit) begin
					emit(CODE_W'(dec_acc), KIND_CHAR, ERR_NONE);
					clear_run();
					plain_step(c, eos);
				end else begin
					emit('0, KIND_ERR, ERR_EMPTY_HEX);
					clear_run();
					if (eos) begin
						emit('0, KIND_END, ERR_NONE);
						dec_mode = MODE_NORMAL;
					end else begin
						dec_mode = MODE_DROP;
					end
				end
			end
			MODE_DROP: begin
				if (eos) begin
					emit('0, KIND_END, ERR_NONE);
					dec_mode = MODE_NORMAL;
				end
			end
			default: begin
				clear_run();
				plain_step(c, eos);
			end
		endcase
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last_in_item = 1'b1;
		foreach (step_out[i])
			want_q.insert(want_q.size(), step_out[i]);
	endfunction

	// --------------------------------------------------------------- stimulus

	function automatic void put_word(input logic [CODE_W-1:0] c, input logic eos);
		src_word_t w;
		w.code    = c;
		w.eos     = eos;
		w.hold    = hold_next;
		hold_next = 1'b0;
		word_q.insert(word_q.size(), w);
	endfunction

	// the code that travels with an end marker is ignored, so make it random
	function automatic void put_end();
		put_word(CODE_W'($urandom_range(0, 2097151)), 1'b1);
	endfunction

	function automatic logic [CODE_W-1:0] hex_char();
		int pick;
		pick = $urandom_range(0, 21);
		if (pick < 10)
			return CH_ZERO + CODE_W'(pick);
		if (pick < 16)
			return CH_LO_A + CODE_W'(pick - 10);
		return CH_UP_A + CODE_W'(pick - 16);
	endfunction

	function automatic logic [CODE_W-1:0] printable();
		logic [CODE_W-1:0] c;
		c = CODE_W'($urandom_range(32, 126));
		return (c == CH_BSLASH) ? CH_X : c;
	endfunction

	// mostly well-formed strings with random content, plus some noise
	function automatic void random_string();
		int segs, ndig;
		segs = $urandom_range(0, 6);
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 8: put_word(printable(), 1'b0);
				2: put_word(CODE_W'($urandom_range(0, 2097151)), 1'b0);
				3: begin
					put_word(CH_BSLASH, 1'b0);
					put_word(ESC_CHARS[$urandom_range(0, 10)], 1'b0);
				end
				4, 9: begin
					put_word(CH_BSLASH, 1'b0);
					put_word(CH_ONE + CODE_W'($urandom_range(0, 6)), 1'b0);
					ndig = $urandom_range(0, 8);
					for (int k = 0; k < ndig; k++)
						put_word(CH_ZERO + CODE_W'($urandom_range(0, 7)), 1'b0);
					if ($urandom_range(0, 2) == 0)
						put_word(CH_NINE - CODE_W'($urandom_range(0, 1)), 1'b0);
				end
				5: begin
					put_word(CH_BSLASH, 1'b0);
					put_word(CH_X, 1'b0);
					ndig = $urandom_range(0, 8);
					for (int k = 0; k < ndig; k++)
						put_word(hex_char(), 1'b0);
				end
				default: begin
					put_word(CH_BSLASH, 1'b0);
					if ($urandom_range(0, 3) == 0)
						put_word(CODE_W'($urandom_range(0, 2097151)), 1'b0);
					else
						put_word(CODE_W'($urandom_range(0, 127)), 1'b0);
				end
			endcase
		end
		if ($urandom_range(0, 11) == 0)
			put_word(CH_BSLASH, 1'b0);
		put_end();
	endfunction

	// ----------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		src_word_t w;
		if (!arst_n) begin
			in_ch.valid         <= 1'b0;
			in_ch.char_code     <= '0;
			in_ch.end_of_string <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				decode_word(in_ch.char_code, in_ch.end_of_string);
				words_sent++;
				if (in_ch.end_of_string)
					strings_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (word_q.size() > 0 && !(word_q[0].hold && want_q.size() > 0)) begin
					w = word_q.pop_front();
					in_ch.valid         <= 1'b1;
					in_ch.char_code     <= w.code;
					in_ch.end_of_string <= w.eos;
					// plan the gap after this word
					if (word_q.size() < TAIL_WORDS)
						src_gap = 0;
					else if (src_run > 0)
						src_run--;
					else if ($urandom_range(0, 4) == 0)
						src_gap = $urandom_range(1, 16);
					else if ($urandom_range(0, 19) == 0)
						src_run = $urandom_range(20, 60);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				case (out_ch.kind)
					KIND_CHAR: chars_seen++;
					KIND_END:  ends_seen++;
					default:   errs_seen++;
				endcase
				if (want_q.size() == 0) begin
					$error("unexpected result word: char_value %h kind %0d error_code %0d",
						out_ch.char_value, out_ch.kind, out_ch.error_code);
					err_cnt++;
				end else begin
					want = want_q.pop_front();
					if (out_ch.char_value !== want.char_value) begin
						$error("char_value: expected %h, got %h", want.char_value,
							out_ch.char_value);
						err_cnt++;
					end
					if (out_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
						err_cnt++;
					end
					if (out_ch.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code,
							out_ch.error_code);
						err_cnt++;
					end
					if (out_ch.last_in_item !== want.last_in_item) begin
						$error("last_in_item: expected %0d, got %0d", want.last_in_item,
							out_ch.last_in_item);
						err_cnt++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (word_q.size() >= TAIL_WORDS) begin
					if (sink_run > 0)
						sink_run--;
					else if ($urandom_range(0, 5) == 0)
						sink_gap = $urandom_range(1, 16);
					else if ($urandom_range(0, 24) == 0)
						sink_run = $urandom_range(20, 60);
				end
			end
		end
	end

	// ------------------------------------------------------------------- main

	initial begin
		int nstr;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.char_code     = '0;
		in_ch.end_of_string = 1'b0;
		out_ch.ready        = 1'b0;
		dec_mode            = MODE_NORMAL;
		clear_run();

		// plain extremes, octal run ended by an eight, run ended by end of string
		put_word('0, 1'b0);
		put_word('1, 1'b0);
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_ONE, 1'b0);
		put_word(CH_SEVEN, 1'b0);
		put_word(CH_NINE - CODE_W'(1), 1'b0);
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_ZERO + CODE_W'(5), 1'b0);
		put_end();
		// hex run in mixed case ended by a backslash that opens a new escape
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_X, 1'b0);
		put_word(CH_LO_A, 1'b0);
		put_word(CH_UP_F, 1'b0);
		put_word(CH_NINE, 1'b0);
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_LO_N, 1'b0);
		put_end();
		// empty hex run at a non-digit, then drop up to the end
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_X, 1'b0);
		put_word(CH_LO_F + CODE_W'(1), 1'b0);
		put_word(CH_BSLASH, 1'b0);
		put_end();
		// empty hex run at end of string
		put_word(CH_BSLASH, 1'b0);
		put_word(CH_X, 1'b0);
		put_end();
		// backslash at end of string
		put_word(CH_BSLASH, 1'b0);
		put_end();
		// unknown escape, rest dropped
		put_word(CH_BSLASH, 1'b0);
		put_word(CODE_W'('h71), 1'b0);
		put_word(CH_BSLASH, 1'b0);
		put_end();

		nstr = 0;
		while (word_q.size() < RANDOM_WORDS) begin
			// hold back now and then until every pending result is out
			if (nstr % 40 == 0)
				hold_next = 1'b1;
			random_string();
			nstr++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (word_q.size() > 0 || in_ch.valid || want_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d words in %0d strings sent; %0d result words checked", words_sent,
			strings_sent, results_seen);
		$display("results: %0d characters, %0d end markers, %0d errors", chars_seen,
			ends_seen, errs_seen);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout: %0d result words still expected", want_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
